@@ hdl/hsvc_pkg.sv @@
// Shared types and constants for the HSV to RGB converter.
package hsvc_pkg;

  // Number of hue sectors around the color wheel.
  localparam int unsigned SECTORS = 6;

  // Hue sector; each value selects one routing of v, p, q and t.
  typedef enum logic [2:0] {
    SECT_RED_YEL = 3'd0,
    SECT_YEL_GRN = 3'd1,
    SECT_GRN_CYN = 3'd2,
    SECT_CYN_BLU = 3'd3,
    SECT_BLU_MAG = 3'd4,
    SECT_MAG_RED = 3'd5
  } sector_t;

endpackage

@@ hdl/hsv_to_rgb_convert_top.sv @@
// Top level of the pipelined HSV to RGB color converter.
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+------------------------------------
//   pixel   | pix_valid / pix_stall | hue, saturation, brightness (in)
//   color   | rgb_valid / rgb_stall | red, green, blue (out)
//
// The converter is a four-stage pipeline and takes one pixel transfer in every
// clock cycle while the output is not stalled. The depth is set by the two rows of
// multipliers: stage one scales the hue, stage two forms s*f and s*(1-f),
// stage three multiplies by the value, and stage four routes the sector.
// Reset clears all stage valid bits; the datapath registers are not reset.
// A stall on a valid color freezes the whole pipeline, and pix_stall is
// raised only while a finished color waits under a stall.
module hsv_to_rgb_convert_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  logic [FRAC_BITS:0]   hue,
  input  logic [FRAC_BITS:0]   saturation,
  input  logic [FRAC_BITS:0]   brightness,
  output logic                 rgb_valid,
  input  logic                 rgb_stall,
  output logic [FRAC_BITS:0]   red,
  output logic [FRAC_BITS:0]   green,
  output logic [FRAC_BITS:0]   blue
);

  import hsvc_pkg::*;

  localparam int unsigned W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  // The pipeline advances as a whole whenever the output register is free to move.
  logic en;
  assign en        = !(rgb_valid && rgb_stall);
  assign pix_stall = !en;

  // Stage one: clamp the inputs to one and split the scaled hue.
  logic [W-1:0]   h_sat;
  logic [W-1:0]   s_sat;
  logic [W-1:0]   v_sat;
  logic [W+1:0]   h_scaled;
  logic [2:0]     sect_raw;
  sector_t        sect_next;
  logic [W-1:0]   f_next;

  assign h_sat    = (hue > ONE) ? ONE : hue;
  assign s_sat    = (saturation > ONE) ? ONE : saturation;
  assign v_sat    = (brightness > ONE) ? ONE : brightness;
  // Six times the hue is four times plus two times, so no multiplier is needed.
  // Six times one still fits in two bits above the input width.
  assign h_scaled = {h_sat, 2'b00} + {1'b0, h_sat, 1'b0};
  assign sect_raw = h_scaled[FRAC_BITS +: 3];

  // A full-turn hue lands in sector six, which wraps back to the start of sector zero.
  always_comb begin
    if (sect_raw >= 3'(SECTORS)) begin
      sect_next = SECT_RED_YEL;
      f_next    = '0;
    end else begin
      sect_next = sector_t'(sect_raw);
      f_next    = {1'b0, h_scaled[FRAC_BITS-1:0]};
    end
  end

  logic           v1;
  sector_t        sect1;
  logic [W-1:0]   f1;
  logic [W-1:0]   s1;
  logic [W-1:0]   val1;

  always_ff @(posedge clk) begin
    if (en) begin
      sect1 <= sect_next;
      f1    <= f_next;
      s1    <= s_sat;
      val1  <= v_sat;
    end
  end

  // Stage two: s*f and s*(1-f) in the multipliers, 1-s alongside.
  logic           v2;
  sector_t        sect2;
  logic [W-1:0]   val2;
  logic [W-1:0]   oms2;
  logic [W-1:0]   sf2;
  logic [W-1:0]   s1f2;

  hsvc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_sf (
    .clk  (clk),
    .en   (en),
    .a    (s1),
    .b    (f1),
    .prod (sf2)
  );

  hsvc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_s1f (
    .clk  (clk),
    .en   (en),
    .a    (s1),
    .b    (ONE - f1),
    .prod (s1f2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sect2 <= sect1;
      val2  <= val1;
      oms2  <= ONE - s1;
    end
  end

  // Stage three: scale the three ramps by the value to get p, q and t.
  logic           v3;
  sector_t        sect3;
  logic [W-1:0]   val3;
  logic [W-1:0]   p3;
  logic [W-1:0]   q3;
  logic [W-1:0]   t3;

  hsvc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_p (
    .clk  (clk),
    .en   (en),
    .a    (val2),
    .b    (oms2),
    .prod (p3)
  );

  hsvc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_q (
    .clk  (clk),
    .en   (en),
    .a    (val2),
    .b    (ONE - sf2),
    .prod (q3)
  );

  hsvc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_t (
    .clk  (clk),
    .en   (en),
    .a    (val2),
    .b    (ONE - s1f2),
    .prod (t3)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sect3 <= sect2;
      val3  <= val2;
    end
  end

  // Stage four: the sector routes v, p, q and t onto the three color channels.
  logic [W-1:0] red_next;
  logic [W-1:0] green_next;
  logic [W-1:0] blue_next;

  always_comb begin
    case (sect3)
      SECT_RED_YEL: begin
        red_next = val3; green_next = t3;   blue_next = p3;
      end
      SECT_YEL_GRN: begin
        red_next = q3;   green_next = val3; blue_next = p3;
      end
      SECT_GRN_CYN: begin
        red_next = p3;   green_next = val3; blue_next = t3;
      end
      SECT_CYN_BLU: begin
        red_next = p3;   green_next = q3;   blue_next = val3;
      end
      SECT_BLU_MAG: begin
        red_next = t3;   green_next = p3;   blue_next = val3;
      end
      default: begin
        red_next = val3; green_next = p3;   blue_next = q3;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  // Valid bits travel with the data and are the only reset state.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      rgb_valid <= 1'b0;
    end else if (en) begin
      v1        <= pix_valid;
      v2        <= v1;
      v3        <= v2;
      rgb_valid <= v3;
    end
  end

  // An accepted pixel always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && !pix_stall) |=> v1)
    else $error("accepted pixel did not enter stage one");

  // The input is held off only by a finished color that waits under a stall.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> (rgb_valid && rgb_stall))
    else $error("pixel stall without a blocked output");

  // p is the floor of the ramp: never above v, and never above q or t.
  a_ramp_order: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (p3 <= val3 && q3 >= p3 && t3 >= p3 && q3 <= val3 && t3 <= val3))
    else $error("p, q, t out of order against v");

  // A moving pipeline carries each valid item one stage further.
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (en && v2) |=> v3)
    else $error("item lost between stages two and three");

endmodule

@@ hdl/hsvc_mul.sv @@
// Registered fixed-point multiplier that truncates the product to the fraction grid.
module hsvc_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS:0]   a,
  input  logic [FRAC_BITS:0]   b,
  output logic [FRAC_BITS:0]   prod
);

  localparam int unsigned W = FRAC_BITS + 1;

  logic [2*W-1:0] full;

  assign full = {{W{1'b0}}, a} * {{W{1'b0}}, b};

  // Both operands are at most one, so the shifted product also fits in W bits.
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full[FRAC_BITS +: W];
    end
  end

endmodule
